// File: hdl/sorted_table_search_core_macros.svh
// ----------------------------------------------------------------------------
// sorted_table_search_core_macros.svh
// Assertion macros for the sorted table search core.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types and codes shared by the sorted table search core.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int POS_BITS   = 10;
    localparam int COUNT_BITS = 11;
    localparam int STRIDE_BITS = 6;
    localparam int IDX_BITS   = 13;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_MISSING  = 2'd1;
    localparam logic [1:0] ST_UNSORTED = 2'd2;

    localparam logic [1:0] M_LINEAR = 2'd0;
    localparam logic [1:0] M_BINARY = 2'd1;
    localparam logic [1:0] M_JUMP   = 2'd2;
    localparam logic [1:0] M_EXP    = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENTRY_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEARCH_METHOD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_JUMP_STRIDE  = 2'd2;

    typedef logic signed [IDX_BITS-1:0] idx_t;

    typedef struct packed {
        logic                       op;
        logic [POS_BITS-1:0]        entry_index;
        logic signed [31:0]         entry_value;
        logic signed [31:0]         search_key;
        logic [POS_BITS-1:0]        range_low;
        logic [POS_BITS-1:0]        range_high;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [POS_BITS-1:0] position;
    } result_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

// File: hdl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/sts_cmp.sv
// ----------------------------------------------------------------------------
// sts_cmp
// Shared signed compare unit: table word against key or previous word.
// ----------------------------------------------------------------------------
module sts_cmp #(
    parameter int WIDTH = 32
) (
    input  logic signed [WIDTH-1:0] a,
    input  logic signed [WIDTH-1:0] b,
    output sts_pkg::cmp_t           flags
);

    assign flags.lt = (a < b);
    assign flags.eq = (a == b);

endmodule

// File: hdl/sorted_table_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_search_core
// Table of signed words with linear, binary, jump and exponential search.
//
//   channel  handshake          payload
//   command  start / busy       cmd    (sts_pkg::cmd_t)
//   result   done (one cycle)   result (sts_pkg::result_t)
//   config   cfg_we             cfg_index, cfg_data
//
// A write command leaves busy low.
// A binary, jump or exponential search first checks the table order (one table
// read a cycle), then runs its scan steps and binary probes, each a read and a
// compare; linear search has no order check. done follows in the first idle cycle.
// The table RAM has a single read port.
// Reset returns control to idle and sets the configuration to entry count 1, binary
// search and stride 1; table contents are not cleared. Results cannot be stalled:
// done marks each result for exactly one cycle.
`include "sorted_table_search_core_macros.svh"

module sorted_table_search_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  sts_pkg::cmd_t                        cmd,
    output logic                                 done,
    output sts_pkg::result_t                     result,
    input  logic                                 cfg_we,
    input  logic [sts_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [sts_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CHECK    = 7'b0000010,
        S_LINEAR   = 7'b0000100,
        S_SCAN_RD  = 7'b0001000,
        S_SCAN_CMP = 7'b0010000,
        S_BIS_RD   = 7'b0100000,
        S_BIS_CMP  = 7'b1000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [sts_pkg::COUNT_BITS-1:0]      count_cfg_reg;
    logic [1:0]                          method_cfg_reg;
    logic [sts_pkg::STRIDE_BITS-1:0]     stride_cfg_reg;

    sts_pkg::idx_t                       cnt_reg, cnt_next;
    logic                                pend_reg, pend_next;
    sts_pkg::idx_t                       pidx_reg, pidx_next;
    logic signed [VALUE_BITS-1:0]        prev_reg, prev_next;
    logic signed [VALUE_BITS-1:0]        key_reg, key_next;
    sts_pkg::idx_t                       n_reg, n_next;
    logic [1:0]                          method_reg, method_next;
    sts_pkg::idx_t                       stride_reg, stride_next;
    logic [sts_pkg::POS_BITS-1:0]        rlo_reg, rlo_next;
    logic [sts_pkg::POS_BITS-1:0]        rhi_reg, rhi_next;
    sts_pkg::idx_t                       lo_reg, lo_next;
    sts_pkg::idx_t                       hi_reg, hi_next;
    sts_pkg::idx_t                       probe_reg, probe_next;
    sts_pkg::idx_t                       mid_reg, mid_next;
    logic                                done_reg, done_next;
    logic [1:0]                          status_reg, status_next;
    logic [sts_pkg::POS_BITS-1:0]        pos_reg, pos_next;

    logic                                ram_we;
    sts_pkg::idx_t                       rd_idx;
    logic signed [VALUE_BITS-1:0]        rd_data;
    logic signed [VALUE_BITS-1:0]        wr_value;
    logic signed [VALUE_BITS-1:0]        cmp_b;
    sts_pkg::cmp_t                       cmp;
    sts_pkg::idx_t                       n_w;
    sts_pkg::idx_t                       last_w;
    sts_pkg::idx_t                       mid_w;
    sts_pkg::idx_t                       jump_left_w;
    sts_pkg::idx_t                       scan_lo_w;
    sts_pkg::idx_t                       scan_hi_w;
    sts_pkg::idx_t                       rhi_w;

    assign wr_value = VALUE_BITS'(cmd.entry_value);
    assign cmp_b    = (state_reg == S_CHECK) ? prev_reg : key_reg;
    assign n_w      = (32'(count_cfg_reg) > TABLE_DEPTH) ? sts_pkg::idx_t'(TABLE_DEPTH)
                                                          : sts_pkg::idx_t'(count_cfg_reg);
    assign last_w   = n_reg - sts_pkg::idx_t'(1);
    assign mid_w    = (lo_reg + hi_reg) >>> 1;
    assign jump_left_w = probe_reg - stride_reg;
    assign scan_lo_w = (method_reg == sts_pkg::M_JUMP)
                       ? ((jump_left_w < 0) ? '0 : jump_left_w)
                       : (probe_reg >>> 1);
    assign scan_hi_w = (probe_reg < last_w) ? probe_reg : last_w;
    assign rhi_w     = (sts_pkg::idx_t'(rhi_reg) < last_w) ? sts_pkg::idx_t'(rhi_reg) : last_w;

    sts_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd.entry_index)),
        .wdata (wr_value),
        .raddr (AW'(rd_idx)),
        .rdata (rd_data)
    );

    sts_cmp #(
        .WIDTH (VALUE_BITS)
    ) u_cmp (
        .a     (rd_data),
        .b     (cmp_b),
        .flags (cmp)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        prev_next   = prev_reg;
        key_next    = key_reg;
        n_next      = n_reg;
        method_next = method_reg;
        stride_next = stride_reg;
        rlo_next    = rlo_reg;
        rhi_next    = rhi_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        probe_next  = probe_reg;
        mid_next    = mid_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        pos_next    = pos_reg;
        ram_we      = 1'b0;
        rd_idx      = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == sts_pkg::OP_WRITE)
                    begin
                        ram_we = (32'(cmd.entry_index) < TABLE_DEPTH);
                    end
                    else
                    begin
                        key_next    = VALUE_BITS'(cmd.search_key);
                        n_next      = n_w;
                        method_next = method_cfg_reg;
                        stride_next = (stride_cfg_reg == '0) ? sts_pkg::idx_t'(1)
                                                             : sts_pkg::idx_t'(stride_cfg_reg);
                        rlo_next    = cmd.range_low;
                        rhi_next    = cmd.range_high;
                        cnt_next    = '0;
                        pend_next   = 1'b0;
                        if (n_w == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = sts_pkg::ST_MISSING;
                            pos_next    = '0;
                        end
                        else if (method_cfg_reg == sts_pkg::M_LINEAR)
                        begin
                            state_next = S_LINEAR;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                end
            end

            S_CHECK, S_LINEAR:
            begin
                rd_idx = cnt_reg;
                if (cnt_reg < n_reg)
                begin
                    cnt_next  = cnt_reg + sts_pkg::idx_t'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (state_reg == S_LINEAR)
                    begin
                        if (cmp.eq)
                        begin
                            done_next   = 1'b1;
                            status_next = sts_pkg::ST_FOUND;
                            pos_next    = sts_pkg::POS_BITS'(pidx_reg);
                            state_next  = S_IDLE;
                        end
                        else if (pidx_reg == last_w)
                        begin
                            done_next   = 1'b1;
                            status_next = sts_pkg::ST_MISSING;
                            pos_next    = '0;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        prev_next = rd_data;
                        if (pidx_reg != '0 && cmp.lt)
                        begin
                            done_next   = 1'b1;
                            status_next = sts_pkg::ST_UNSORTED;
                            pos_next    = '0;
                            state_next  = S_IDLE;
                        end
                        else if (pidx_reg == last_w)
                        begin
                            case (method_reg)
                                sts_pkg::M_JUMP:
                                begin
                                    probe_next = '0;
                                    state_next = S_SCAN_RD;
                                end
                                sts_pkg::M_EXP:
                                begin
                                    probe_next = sts_pkg::idx_t'(1);
                                    state_next = S_SCAN_RD;
                                end
                                default:
                                begin
                                    lo_next    = sts_pkg::idx_t'(rlo_reg);
                                    hi_next    = rhi_w;
                                    state_next = S_BIS_RD;
                                end
                            endcase
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                rd_idx = probe_reg;
                if (probe_reg < n_reg)
                begin
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    lo_next    = scan_lo_w;
                    hi_next    = scan_hi_w;
                    state_next = S_BIS_RD;
                end
            end

            S_SCAN_CMP:
            begin
                rd_idx = probe_reg;
                if (cmp.lt)
                begin
                    probe_next = (method_reg == sts_pkg::M_JUMP) ? (probe_reg + stride_reg)
                                                                 : (probe_reg <<< 1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    lo_next    = scan_lo_w;
                    hi_next    = scan_hi_w;
                    state_next = S_BIS_RD;
                end
            end

            S_BIS_RD:
            begin
                rd_idx = mid_w;
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid_w;
                    state_next = S_BIS_CMP;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = sts_pkg::ST_MISSING;
                    pos_next    = '0;
                    state_next  = S_IDLE;
                end
            end

            S_BIS_CMP:
            begin
                rd_idx = mid_reg;
                if (cmp.eq)
                begin
                    done_next   = 1'b1;
                    status_next = sts_pkg::ST_FOUND;
                    pos_next    = sts_pkg::POS_BITS'(mid_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (cmp.lt)
                    begin
                        lo_next = mid_reg + sts_pkg::idx_t'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg - sts_pkg::idx_t'(1);
                    end
                    state_next = S_BIS_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_reg       <= 1'b0;
            done_reg       <= 1'b0;
            count_cfg_reg  <= sts_pkg::COUNT_BITS'(1);
            method_cfg_reg <= sts_pkg::M_BINARY;
            stride_cfg_reg <= sts_pkg::STRIDE_BITS'(1);
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sts_pkg::CFG_ENTRY_COUNT:
                    begin
                        count_cfg_reg <= cfg_data;
                    end
                    sts_pkg::CFG_SEARCH_METHOD:
                    begin
                        method_cfg_reg <= cfg_data[1:0];
                    end
                    sts_pkg::CFG_JUMP_STRIDE:
                    begin
                        stride_cfg_reg <= cfg_data[sts_pkg::STRIDE_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        prev_reg   <= prev_next;
        key_reg    <= key_next;
        n_reg      <= n_next;
        method_reg <= method_next;
        stride_reg <= stride_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        probe_reg  <= probe_next;
        mid_reg    <= mid_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign result.status   = status_reg;
    assign result.position = pos_reg;

    `STS_ASSERT_IMPLY(a_done_idle, done, !busy, "result strobe while busy")
    `STS_ASSERT_NEXT(a_search_progress, start && !busy && cmd.op == sts_pkg::OP_SEARCH,
        busy || done, "search transfer neither started nor finished")
    `STS_ASSERT_IMPLY(a_pos_zero, done && result.status != sts_pkg::ST_FOUND,
        result.position == '0, "nonzero position without a match")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_table_search_core. A short directed table
// covers field extremes, every search method and the corner cases; random
// phases then reprogram the core, load mostly ascending tables and query them.
// Search results are checked against fixed expected values or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH        = 1024;
    localparam int VAL_MIN      = 32'sh8000_0000;
    localparam int VAL_MAX      = 32'sh7fff_ffff;
    localparam int RANDOM_ITEMS = 517;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int CMD_BITS     = $bits(sts_pkg::cmd_t);
    localparam logic [sts_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef enum {ROW_CFG, ROW_WRITE, ROW_FIND} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        int               a;
        int               b;
        int               c;
        bit               chk;
        sts_pkg::result_t want;
    } row_t;

    logic                              clk;
    logic                              rst_n     = 1'b0;
    logic                              start     = 1'b0;
    logic                              busy;
    sts_pkg::cmd_t                     cmd       = '0;
    logic                              done;
    sts_pkg::result_t                  result;
    logic                              cfg_we    = 1'b0;
    logic [sts_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [sts_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    int         tbl_mem [DEPTH];
    int         count_reg  = 1;
    logic [1:0] method_reg = sts_pkg::M_BINARY;
    int         stride_reg = 1;

    sts_pkg::result_t due_results [$];
    sts_pkg::result_t head;
    row_t             plan [$];
    int               mismatches     = 0;
    int               idle_cycles    = 0;
    int               burst_left     = 0;
    int               prefix_written = 0;

    sorted_table_search_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int bisect_range(int key, int lo, int hi);
        int mid;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (tbl_mem[mid] == key)
                return mid;
            if (tbl_mem[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic sts_pkg::result_t search_outcome(sts_pkg::cmd_t c);
        int               n, key, found, lo, hi, step, idx, f, i;
        sts_pkg::result_t r;
        key        = c.search_key;
        n          = (count_reg > DEPTH) ? DEPTH : count_reg;
        found      = -1;
        r.status   = sts_pkg::ST_MISSING;
        r.position = '0;
        if (method_reg != sts_pkg::M_LINEAR)
            for (i = 1; i < n; i++)
                if (tbl_mem[i] < tbl_mem[i-1])
                begin
                    r.status = sts_pkg::ST_UNSORTED;
                    return r;
                end
        if (n > 0)
            case (method_reg)
                sts_pkg::M_LINEAR:
                    for (i = 0; i < n && found < 0; i++)
                        if (tbl_mem[i] == key)
                            found = i;
                sts_pkg::M_BINARY:
                begin
                    lo = c.range_low;
                    hi = c.range_high;
                    if (hi > n - 1)
                        hi = n - 1;
                    found = bisect_range(key, lo, hi);
                end
                sts_pkg::M_JUMP:
                begin
                    step = (stride_reg == 0) ? 1 : stride_reg;
                    idx  = 0;
                    while (idx < n && tbl_mem[idx] < key)
                        idx += step;
                    lo = (idx - step < 0) ? 0 : idx - step;
                    hi = (idx < n - 1) ? idx : n - 1;
                    found = bisect_range(key, lo, hi);
                end
                sts_pkg::M_EXP:
                begin
                    f = 1;
                    while (f < n && tbl_mem[f] < key)
                        f = f * 2;
                    hi = (f < n - 1) ? f : n - 1;
                    found = bisect_range(key, f / 2, hi);
                end
                default: ;
            endcase
        if (found >= 0)
        begin
            r.status   = sts_pkg::ST_FOUND;
            r.position = sts_pkg::POS_BITS'(found);
        end
        return r;
    endfunction

    function automatic sts_pkg::cmd_t write_cmd(int idx, int val);
        sts_pkg::cmd_t c;
        c = CMD_BITS'({$urandom, $urandom, $urandom});
        c.op          = sts_pkg::OP_WRITE;
        c.entry_index = sts_pkg::POS_BITS'(idx);
        c.entry_value = val;
        return c;
    endfunction

    function automatic sts_pkg::cmd_t search_cmd(int key, int lo, int hi);
        sts_pkg::cmd_t c;
        c = CMD_BITS'({$urandom, $urandom, $urandom});
        c.op         = sts_pkg::OP_SEARCH;
        c.search_key = key;
        c.range_low  = sts_pkg::POS_BITS'(lo);
        c.range_high = sts_pkg::POS_BITS'(hi);
        return c;
    endfunction

    function automatic void add_row(row_kind_t kind, int a, int b = 0, int c = 0,
                                    bit chk = 1'b0, logic [1:0] st = sts_pkg::ST_FOUND,
                                    int pos = 0);
        row_t r;
        r.kind          = kind;
        r.a             = a;
        r.b             = b;
        r.c             = c;
        r.chk           = chk;
        r.want.status   = st;
        r.want.position = sts_pkg::POS_BITS'(pos);
        plan.push_back(r);
    endfunction

    task automatic set_reg(int idx, int data);
        logic [sts_pkg::CFG_IDX_BITS-1:0] ri;
        ri = sts_pkg::CFG_IDX_BITS'(idx);
        start <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0 || busy);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= sts_pkg::CFG_DATA_BITS'(data);
        @(posedge clk);
        case (ri)
            sts_pkg::CFG_ENTRY_COUNT:   count_reg  = data[sts_pkg::COUNT_BITS-1:0];
            sts_pkg::CFG_SEARCH_METHOD: method_reg = data[1:0];
            sts_pkg::CFG_JUMP_STRIDE:   stride_reg = data[sts_pkg::STRIDE_BITS-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic issue(sts_pkg::cmd_t c, bit chk, sts_pkg::result_t want);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 3))
                @(posedge clk);
            burst_left = $urandom_range(1, 25);
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (c.op == sts_pkg::OP_SEARCH)
            due_results.push_back(chk ? want : search_outcome(c));
        else
            tbl_mem[c.entry_index] = c.entry_value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result: status %0d position %0d",
                             result.status, result.position);
                mismatches++;
            end
            else
            begin
                head = due_results.pop_front();
                if (result.status !== head.status || result.position !== head.position)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("result mismatch: expected status %0d position %0d, %s",
                                 head.status, head.position,
                                 $sformatf("got status %0d position %0d",
                                           result.status, result.position));
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int               k, n, count, phase, items_done, steps, shape, s, i, j, tmp, key;
        int               lo, hi, meth;
        bit               wide;
        int unsigned      span;
        longint           acc;
        int               vals [$];
        sts_pkg::result_t nothing;

        nothing = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_row(ROW_WRITE, 0, VAL_MIN);
        add_row(ROW_FIND, VAL_MIN, 0, 0, 1'b1, sts_pkg::ST_FOUND, 0);
        add_row(ROW_FIND, VAL_MAX, 0, 1023, 1'b1, sts_pkg::ST_MISSING, 0);
        add_row(ROW_FIND, 0, 1023, 1023, 1'b1, sts_pkg::ST_MISSING, 0);
        add_row(ROW_WRITE, 1, -5);
        add_row(ROW_WRITE, 2, 0);
        add_row(ROW_WRITE, 3, 7);
        add_row(ROW_WRITE, 4, VAL_MAX);
        add_row(ROW_WRITE, 1023, -1);
        add_row(ROW_CFG, sts_pkg::CFG_ENTRY_COUNT, 5);
        add_row(ROW_FIND, 7, 0, 1023);
        add_row(ROW_FIND, 8, 0, 1023);
        add_row(ROW_CFG, sts_pkg::CFG_SEARCH_METHOD, sts_pkg::M_LINEAR);
        add_row(ROW_FIND, -1, 0, 0);
        add_row(ROW_FIND, VAL_MAX, 0, 0);
        add_row(ROW_CFG, sts_pkg::CFG_SEARCH_METHOD, sts_pkg::M_JUMP);
        add_row(ROW_CFG, sts_pkg::CFG_JUMP_STRIDE, 2);
        add_row(ROW_FIND, VAL_MAX, 0, 0);
        add_row(ROW_FIND, -5, 0, 0);
        add_row(ROW_CFG, sts_pkg::CFG_JUMP_STRIDE, 0);
        add_row(ROW_FIND, 0, 0, 0);
        add_row(ROW_CFG, sts_pkg::CFG_SEARCH_METHOD, sts_pkg::M_EXP);
        add_row(ROW_FIND, VAL_MIN, 0, 0);
        add_row(ROW_FIND, 7, 0, 0);
        add_row(ROW_WRITE, 2, 100);
        add_row(ROW_FIND, 7, 0, 1023, 1'b1, sts_pkg::ST_UNSORTED, 0);
        add_row(ROW_CFG, sts_pkg::CFG_ENTRY_COUNT, 0);
        add_row(ROW_FIND, 7, 0, 1023, 1'b1, sts_pkg::ST_MISSING, 0);
        add_row(ROW_CFG, CFG_UNUSED, 2047);
        add_row(ROW_CFG, sts_pkg::CFG_ENTRY_COUNT, 5);
        add_row(ROW_CFG, sts_pkg::CFG_SEARCH_METHOD, sts_pkg::M_LINEAR);
        add_row(ROW_FIND, 100, 0, 0);
        add_row(ROW_CFG, sts_pkg::CFG_JUMP_STRIDE, 63);
        add_row(ROW_CFG, sts_pkg::CFG_SEARCH_METHOD, sts_pkg::M_JUMP);
        add_row(ROW_FIND, 100, 0, 0, 1'b1, sts_pkg::ST_UNSORTED, 0);

        for (k = 0; k < plan.size(); k++)
            case (plan[k].kind)
                ROW_CFG:   set_reg(plan[k].a, plan[k].b);
                ROW_WRITE: issue(write_cmd(plan[k].a, plan[k].b), 1'b0, nothing);
                default:   issue(search_cmd(plan[k].a, plan[k].b, plan[k].c),
                                 plan[k].chk, plan[k].want);
            endcase
        prefix_written = 5;

        phase      = 0;
        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            // counts above the depth: linear search for keys in the loaded prefix
            wide = (phase == 3 || phase == 7);
            if (wide)
                count = $urandom_range(DEPTH + 1, 2047);
            else
                case ($urandom_range(0, 15))
                    0:       count = 0;
                    1:       count = 1;
                    2:       count = 2;
                    3:       count = $urandom_range(65, 100);
                    default: count = $urandom_range(3, 48);
                endcase
            n = (count > DEPTH) ? DEPTH : count;

            s = 1;
            while ((s + 1) * (s + 1) <= n)
                s++;
            case ($urandom_range(0, 5))
                0:       s = 0;
                1:       s = 63;
                2:       ;
                default: s = $urandom_range(1, 32);
            endcase
            meth = wide ? sts_pkg::M_LINEAR : $urandom_range(0, 3);
            set_reg(sts_pkg::CFG_ENTRY_COUNT, count);
            set_reg(sts_pkg::CFG_SEARCH_METHOD, ($urandom_range(0, 511) << 2) | meth);
            set_reg(sts_pkg::CFG_JUMP_STRIDE, ($urandom_range(0, 31) << 6) | s);
            if ($urandom_range(0, 7) == 0)
                set_reg(CFG_UNUSED, $urandom_range(0, 2047));

            // reload the table, mostly ascending, sometimes random or with one adjacent swap
            if (!wide && (n > prefix_written || $urandom_range(0, 3) != 0))
            begin
                vals.delete();
                shape = $urandom_range(0, 9);
                case ($urandom_range(0, 3))
                    0:       acc = VAL_MIN;
                    1:       acc = VAL_MAX - $urandom_range(0, 1000);
                    default: acc = int'($urandom);
                endcase
                case ($urandom_range(0, 2))
                    0:       span = 2;
                    1:       span = 1000;
                    default: span = 32'hffff_ffff / (n + 1);
                endcase
                for (i = 0; i < n; i++)
                begin
                    if (shape == 8)
                        vals.push_back(int'($urandom));
                    else
                    begin
                        vals.push_back(int'((acc > VAL_MAX) ? VAL_MAX : acc));
                        acc = acc + $urandom_range(0, span);
                    end
                end
                if (shape == 9 && n >= 2)
                begin
                    i           = $urandom_range(0, n - 2);
                    tmp         = vals[i];
                    vals[i]     = vals[i + 1];
                    vals[i + 1] = tmp;
                end
                for (i = 0; i < n; i++)
                    issue(write_cmd(i, vals[i]), 1'b0, nothing);
                items_done += n;
                if (n > prefix_written)
                    prefix_written = n;
            end

            steps = $urandom_range(5, 20);
            for (j = 0; j < steps; j++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    i = (n > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1)
                                                             : $urandom_range(0, DEPTH - 1);
                    issue(write_cmd(i, ($urandom_range(0, 1) == 1) ? tbl_mem[i]
                                                                   : int'($urandom)),
                          1'b0, nothing);
                end
                else
                begin
                    if (n == 0)
                        key = $urandom;
                    else if (wide)
                        key = tbl_mem[$urandom_range(0, prefix_written - 1)];
                    else
                    begin
                        i = $urandom_range(0, n - 1);
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: key = tbl_mem[i];
                            10, 11:                       key = tbl_mem[i] + 1;
                            12:                           key = tbl_mem[i] - 1;
                            13, 14, 15:                   key = $urandom;
                            16:                           key = VAL_MIN;
                            17:                           key = VAL_MAX;
                            18:                           key = tbl_mem[0] - 1;
                            default:                      key = tbl_mem[n - 1] + 1;
                        endcase
                    end
                    case ((n == 0) ? 0 : $urandom_range(0, 7))
                        0:
                        begin
                            lo = $urandom_range(0, DEPTH - 1);
                            hi = $urandom_range(0, DEPTH - 1);
                        end
                        1:
                        begin
                            lo = 0;
                            hi = DEPTH - 1;
                        end
                        2:
                        begin
                            lo = $urandom_range(1, DEPTH - 1);
                            hi = lo - 1;
                        end
                        default:
                        begin
                            lo = $urandom_range(0, n - 1);
                            hi = $urandom_range(lo, (n + 4 > DEPTH - 1) ? DEPTH - 1 : n + 4);
                        end
                    endcase
                    issue(search_cmd(key, lo, hi), 1'b0, nothing);
                end
            end
            items_done += steps;
            phase++;
        end

        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
